// ----- rtl/stereo_fir_256_tap_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the stereo FIR block
// Implication checks sampled on the rising clock edge, held off during reset.
// ---------------------------------------------------------------------------
`ifndef STEREO_FIR_256_TAP_DEFINES_SVH
`define STEREO_FIR_256_TAP_DEFINES_SVH

// Same-cycle implication.
`define SFT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sft_pkg.sv -----
// ---------------------------------------------------------------------------
// sft_pkg
// Sizes, word layouts, codes and control types shared by the stereo FIR.
// ---------------------------------------------------------------------------
package sft_pkg;

   // Tap count must stay a power of two: the delay line wraps by address overflow.
   localparam int NUM_TAPS    = 256;
   localparam int TAP_AW      = $clog2(NUM_TAPS);
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int INDEX_BITS  = 8;
   localparam int ACC_BITS    = 48;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;

   localparam logic [TAP_AW-1:0] TAP_LAST = TAP_AW'(NUM_TAPS - 1);

   // Request word layout, lowest bit first.
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_COEF_LSB  = REQ_IDX_LSB + INDEX_BITS;
   localparam int REQ_LEFT_LSB  = REQ_COEF_LSB + COEF_BITS;
   localparam int REQ_RIGHT_LSB = REQ_LEFT_LSB + SAMPLE_BITS;
   localparam int REQ_USED_BITS = REQ_RIGHT_LSB + SAMPLE_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;

   // Response word layout, lowest bit first.
   localparam int RSP_LEFT_LSB  = 0;
   localparam int RSP_RIGHT_LSB = SAMPLE_BITS;
   localparam int RSP_USED_BITS = 2 * SAMPLE_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;

   // Item kinds carried on the request tuser bit.
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_FRAME = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN
   } sft_state_type;

   typedef struct packed {
      logic              clear;      // write zero at tap into every memory
      logic              coef_we;    // load coefficient from the request
      logic              hist_we;    // push the request frame into the delay lines
      logic              issue;      // read coefficient and sample for tap
      logic              acc_clear;  // zero both accumulators
      logic              finish;     // round, saturate, capture result, advance slot
      logic [TAP_AW-1:0] tap;
   } sft_cmd_type;

   typedef struct packed {
      logic busy;                    // read or multiply stage still holds a tap
   } sft_status_type;

endpackage

// ----- rtl/sft_ram.sv -----
// ---------------------------------------------------------------------------
// sft_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module sft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/sft_datapath.sv -----
// ---------------------------------------------------------------------------
// sft_datapath
// Coefficient and delay-line memories, two multiply-accumulate lanes and
// the rounding, saturating result register.
// ---------------------------------------------------------------------------
module sft_datapath
   import sft_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  sft_cmd_type                   cmd,
   input  logic        [INDEX_BITS-1:0]  coef_index,
   input  logic signed [COEF_BITS-1:0]   coef_value,
   input  logic signed [SAMPLE_BITS-1:0] left_in,
   input  logic signed [SAMPLE_BITS-1:0] right_in,
   output logic signed [SAMPLE_BITS-1:0] left_out,
   output logic signed [SAMPLE_BITS-1:0] right_out,
   output sft_status_type                status
);

   localparam int RND_BITS = ACC_BITS + 1;
   localparam int SH_BITS  = RND_BITS - (COEF_BITS - 1);
   localparam logic signed [SH_BITS-1:0] SAT_HI = SH_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SH_BITS-1:0] SAT_LO = -SH_BITS'(1 << (SAMPLE_BITS - 1));
   localparam logic signed [RND_BITS-1:0] RND_HALF = RND_BITS'(1 << (COEF_BITS - 2));

   logic [TAP_AW-1:0] wpos_ff, wpos_in;
   logic              rd_vld_ff, prod_vld_ff;

   logic              coef_we, hist_we, index_ok;
   logic [TAP_AW-1:0] coef_addr, hist_addr;
   logic [COEF_BITS-1:0]   coef_wdata, coef_rd;
   logic [SAMPLE_BITS-1:0] left_wdata, right_wdata, left_rd, right_rd;

   logic signed [PROD_BITS-1:0] prod_l_ff, prod_r_ff;
   logic signed [ACC_BITS-1:0]  acc_l_ff, acc_r_ff;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff;

   // Memory ports: clearing sweep, request writes, or tap reads.
   always_comb begin
      index_ok    = 32'(coef_index) < NUM_TAPS;
      coef_we     = cmd.clear | (cmd.coef_we & index_ok);
      hist_we     = cmd.clear | cmd.hist_we;
      coef_addr   = cmd.coef_we ? coef_index[TAP_AW-1:0] : cmd.tap;
      coef_wdata  = cmd.clear ? '0 : coef_value;
      left_wdata  = cmd.clear ? '0 : left_in;
      right_wdata = cmd.clear ? '0 : right_in;
      if (cmd.clear) begin
         hist_addr = cmd.tap;
      end else if (cmd.hist_we) begin
         hist_addr = wpos_ff;
      end else begin
         hist_addr = wpos_ff - cmd.tap;   // sample k frames ago
      end
   end

   sft_ram #(.WIDTH(COEF_BITS), .DEPTH(NUM_TAPS)) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .addr  (coef_addr),
      .wdata (coef_wdata),
      .rdata (coef_rd)
   );

   sft_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NUM_TAPS)) u_left_ram (
      .clock (clock),
      .we    (hist_we),
      .addr  (hist_addr),
      .wdata (left_wdata),
      .rdata (left_rd)
   );

   sft_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NUM_TAPS)) u_right_ram (
      .clock (clock),
      .we    (hist_we),
      .addr  (hist_addr),
      .wdata (right_wdata),
      .rdata (right_rd)
   );

   assign wpos_in = cmd.finish ? wpos_ff + 1'b1 : wpos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         wpos_ff     <= wpos_in;
         rd_vld_ff   <= cmd.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // Multiply stage.
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_l_ff <= $signed(coef_rd) * $signed(left_rd);
         prod_r_ff <= $signed(coef_rd) * $signed(right_rd);
      end
   end

   // Accumulate stage.
   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_l_ff <= acc_l_ff + {{(ACC_BITS-PROD_BITS){prod_l_ff[PROD_BITS-1]}}, prod_l_ff};
         acc_r_ff <= acc_r_ff + {{(ACC_BITS-PROD_BITS){prod_r_ff[PROD_BITS-1]}}, prod_r_ff};
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [RND_BITS-1:0] rnd;
      logic signed [SH_BITS-1:0]  sh;
      rnd = $signed({acc[ACC_BITS-1], acc}) + RND_HALF;
      sh  = rnd[RND_BITS-1:COEF_BITS-1];
      if (sh > SAT_HI) begin
         round_sat = SAT_HI[SAMPLE_BITS-1:0];
      end else if (sh < SAT_LO) begin
         round_sat = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         round_sat = sh[SAMPLE_BITS-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_l_ff <= round_sat(acc_l_ff);
         out_r_ff <= round_sat(acc_r_ff);
      end
   end

   assign left_out    = out_l_ff;
   assign right_out   = out_r_ff;
   assign status.busy = rd_vld_ff | prod_vld_ff;

endmodule

// ----- rtl/sft_ctrl.sv -----
// ---------------------------------------------------------------------------
// sft_ctrl
// Sequencer: clearing sweep after reset, item intake, tap walk, drain and
// result hand-off.
// ---------------------------------------------------------------------------
module sft_ctrl
   import sft_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_action,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  sft_status_type status,
   output sft_cmd_type    cmd
);

   sft_state_type     state_ff, state_in;
   logic [TAP_AW-1:0] tap_ff, tap_in;
   logic              out_full_ff, out_full_in;
   logic              accept, finish_ok;

   assign accept    = req_tvalid & req_tready;
   assign finish_ok = (state_ff == ST_DRAIN) & ~status.busy & (~out_full_ff | rsp_tready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      tap_in   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_action == ACT_FRAME) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      cmd.clear     = (state_ff == ST_CLEAR);
      cmd.coef_we   = accept & (req_action == ACT_LOAD);
      cmd.hist_we   = accept & (req_action == ACT_FRAME);
      cmd.acc_clear = accept & (req_action == ACT_FRAME);
      cmd.issue     = (state_ff == ST_MAC);
      cmd.finish    = finish_ok;
      cmd.tap       = tap_ff;
   end

   always_comb begin
      priority if (finish_ok) begin
         out_full_in = 1'b1;
      end else if (rsp_tready) begin
         out_full_in = 1'b0;
      end else begin
         out_full_in = out_full_ff;
      end
   end

   assign rsp_tvalid = out_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         tap_ff      <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tap_ff      <= tap_in;
         out_full_ff <= out_full_in;
      end
   end

endmodule

// ----- rtl/stereo_fir_256_tap.sv -----
// ---------------------------------------------------------------------------
// stereo_fir_256_tap
// 256-tap direct-form FIR, shared coefficients, separate left/right delay lines.
// ---------------------------------------------------------------------------
// Flow: after a frame word is accepted the sequencer issues all 256 tap
//   reads, then multiply, accumulate, and round and capture; rsp_tvalid rises once captured.
// Intake: a new frame waits for the last result's capture, as the single MAC lane per
//   channel walks all 256 taps; a result held by rsp_tready delays it. Loads go back to back.
// Reset: synchronous; a sweep over all 256 addresses then zeros coefficients and delay lines,
//   with req_tready low throughout.
`include "stereo_fir_256_tap_defines.svh"

module stereo_fir_256_tap
   import sft_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request channel.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // coef_index[7:0], coef_value[23:8], left_in[39:24], right_in[55:40]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // action[0]: 0 loads a coefficient, 1 pushes a stereo frame
   input  logic [0:0]               req_tuser,
   // Response channel.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // left_out[15:0], right_out[31:16]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   sft_cmd_type    cmd;
   sft_status_type status;

   logic        [INDEX_BITS-1:0]  coef_index;
   logic signed [COEF_BITS-1:0]   coef_value;
   logic signed [SAMPLE_BITS-1:0] left_in, right_in, left_out, right_out;

   // Unpack the request word; a load uses only index and value, a frame only
   // the two samples.
   assign coef_index = req_tdata[REQ_IDX_LSB +: INDEX_BITS];
   assign coef_value = req_tdata[REQ_COEF_LSB +: COEF_BITS];
   assign left_in    = req_tdata[REQ_LEFT_LSB +: SAMPLE_BITS];
   assign right_in   = req_tdata[REQ_RIGHT_LSB +: SAMPLE_BITS];

   // The sequencer owns the handshake and the tap counter; it hands the
   // datapath one command word per cycle.
   sft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the memories, the write slot, both MAC lanes and the
   // result register, which keeps the last result while the next frame runs.
   sft_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .coef_index (coef_index),
      .coef_value (coef_value),
      .left_in    (left_in),
      .right_in   (right_in),
      .left_out   (left_out),
      .right_out  (right_out),
      .status     (status)
   );

   // Pack the response word, zero-filling any spare bits.
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_LEFT_LSB +: SAMPLE_BITS]  = left_out;
      rsp_tdata[RSP_RIGHT_LSB +: SAMPLE_BITS] = right_out;
   end

   // A new word never lands while taps are still in flight.
   `SFT_ASSERT_SAME(a_accept_idle, req_tvalid && req_tready, !status.busy,
                    "word accepted while MAC pipeline busy")
   // A result is captured only when the response slot is free or draining.
   `SFT_ASSERT_SAME(a_finish_slot, cmd.finish, !rsp_tvalid || rsp_tready,
                    "result overwrote a pending response")
   // A captured result is offered on the next cycle.
   `SFT_ASSERT_NEXT(a_finish_valid, cmd.finish, rsp_tvalid,
                    "captured result not offered")
   // The clearing sweep never overlaps intake.
   `SFT_ASSERT_SAME(a_clear_block, cmd.clear, !req_tready && !cmd.issue,
                    "clearing sweep overlaps intake or tap walk")

endmodule
